>>> hw/rtl/fdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus distance tracker package
// Shared constants, register indexes, mode codes, the exponential tables and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package fdt_pkg;

    // Field widths.
    localparam int DIST_W  = 17;
    localparam int DEPTH_W = 18;
    localparam int TIME_W  = 16;
    localparam int RATE_W  = 16;
    localparam int MODE_W  = 2;
    localparam int K_W     = 17;
    localparam int Q30_W   = 31;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_HOLD    = 3'd6;

    // Register reset values.
    localparam logic [DIST_W-1:0] RST_MIN_DISTANCE   = 17'd128;
    localparam logic [DIST_W-1:0] RST_MAX_DISTANCE   = 17'd65536;
    localparam logic [RATE_W-1:0] RST_EASE_RATE      = 16'd1536;
    localparam logic [DIST_W-1:0] RST_DEADBAND       = 17'd192;
    localparam logic [TIME_W-1:0] RST_LOST_TIMEOUT   = 16'd16384;
    localparam logic [DIST_W-1:0] RST_START_DISTANCE = 17'd2560;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_LOCKED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEEKING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MANUAL  = 2'd3;

    // Exponential tables.
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int POS_W             = 24 + EXP_IDX_W;
    localparam int INT_LIMIT         = 12;
    localparam int INT_IDX_W         = $clog2(INT_LIMIT);
    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;

    typedef logic [Q30_W-1:0] frac_tab_t [0:EXP_TABLE_ENTRIES];
    typedef logic [Q30_W-1:0] int_tab_t [0:INT_LIMIT-1];

    // Division of a series term by a small fixed divisor.
    function automatic logic [63:0] div_small(input logic [63:0] value, input int n);
        unique case (n)
            1:       return value / 1;
            2:       return value / 2;
            3:       return value / 3;
            4:       return value / 4;
            5:       return value / 5;
            6:       return value / 6;
            7:       return value / 7;
            8:       return value / 8;
            9:       return value / 9;
            10:      return value / 10;
            11:      return value / 11;
            12:      return value / 12;
            13:      return value / 13;
            14:      return value / 14;
            15:      return value / 15;
            16:      return value / 16;
            default: return value;
        endcase
    endfunction

    // exp(-f) for f in Q1.30 between 0 and 1, by a truncated Taylor series.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 16; n++) begin
            term = div_small((term * f) >> 30, n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Entry i holds exp(-i / EXP_TABLE_ENTRIES) in Q1.30.
    function automatic frac_tab_t build_frac_exp();
        frac_tab_t tab;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
            tab[i] = Q30_W'(exp_neg_q30((64'(i) << 30) / EXP_TABLE_ENTRIES));
        end
        return tab;
    endfunction

    // Entry n holds exp(-n) in Q1.30, built by repeated rounded products.
    function automatic int_tab_t build_int_exp();
        int_tab_t    tab;
        logic [63:0] e1;
        logic [63:0] acc;
        e1     = exp_neg_q30(ONE_Q30);
        tab[0] = Q30_W'(ONE_Q30);
        tab[1] = Q30_W'(e1);
        acc    = e1;
        for (int i = 2; i < INT_LIMIT; i++) begin
            acc    = (acc * e1 + (64'd1 << 29)) >> 30;
            tab[i] = Q30_W'(acc);
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_EXP = build_frac_exp();
    localparam int_tab_t  INT_EXP  = build_int_exp();

    // Clamp with the lower bound checked first.
    function automatic logic [DIST_W-1:0] clamp_dist(input logic [DIST_W-1:0] v,
                                                     input logic [DIST_W-1:0] lo,
                                                     input logic [DIST_W-1:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic track;
        logic pos;
        logic rd_a;
        logic rd_b;
        logic interp;
        logic scale;
        logic kcalc;
        logic ease;
        logic load_out;
    } fdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
    } fdt_status_t;

endpackage

>>> hw/rtl/fdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus distance tracker controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module fdt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fdt_pkg::fdt_status_t status,
    output fdt_pkg::fdt_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_TRACK  = 10'b00_0000_0010,
        S_POS    = 10'b00_0000_0100,
        S_RDA    = 10'b00_0000_1000,
        S_RDB    = 10'b00_0001_0000,
        S_INTERP = 10'b00_0010_0000,
        S_SCALE  = 10'b00_0100_0000,
        S_KCALC  = 10'b00_1000_0000,
        S_EASE   = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;
    assign out_free = !valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_TRACK;
                end
            end
            S_TRACK:  state_next = status.skip ? S_OUT : S_POS;
            S_POS:    state_next = S_RDA;
            S_RDA:    state_next = S_RDB;
            S_RDB:    state_next = S_INTERP;
            S_INTERP: state_next = S_SCALE;
            S_SCALE:  state_next = S_KCALC;
            S_KCALC:  state_next = S_EASE;
            S_EASE:   state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd.latch_in = (state_reg == S_IDLE) && s_tvalid;
        cmd.track    = (state_reg == S_TRACK) && !status.skip;
        cmd.pos      = (state_reg == S_POS);
        cmd.rd_a     = (state_reg == S_RDA);
        cmd.rd_b     = (state_reg == S_RDB);
        cmd.interp   = (state_reg == S_INTERP);
        cmd.scale    = (state_reg == S_SCALE);
        cmd.kcalc    = (state_reg == S_KCALC);
        cmd.ease     = (state_reg == S_EASE);
        cmd.load_out = (state_reg == S_OUT) && out_free;
    end

    // The result flag is set on load and dropped once the item is taken.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // An accepted item always starts at the tracking step.
    a_accept_to_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_TRACK))
        else $error("accepted item did not enter tracking");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid && !m_tready) |-> !cmd.load_out)
        else $error("result loaded over a waiting item");

    // The ease step is always followed by the result step.
    a_ease_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EASE) |=> (state_reg == S_OUT))
        else $error("ease step not followed by result");

    // After the tracking step, the core is never both ready and tracking.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRACK) |=> !(s_tready && state_reg == S_TRACK))
        else $error("tracking step repeated");

endmodule

>>> hw/rtl/fdt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus distance tracker datapath
// Configuration and tracking state, the exponential ease factor and the
// result register, each step run on a command from the controller.
// ----------------------------------------------------------------------------
module fdt_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fdt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [fdt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic [fdt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  fdt_pkg::fdt_cmd_t                 cmd,
    output fdt_pkg::fdt_status_t              status
);

    localparam int DW = fdt_pkg::DIST_W;
    localparam int QW = fdt_pkg::Q30_W;
    localparam int IW = fdt_pkg::EXP_IDX_W;
    localparam int POS_TOP = fdt_pkg::POS_W - 1;

    // Configuration registers.
    logic [DW-1:0]                  min_reg, max_reg, deadband_reg;
    logic [fdt_pkg::RATE_W-1:0]     rate_reg;
    logic [fdt_pkg::TIME_W-1:0]     timeout_reg;
    logic                           manual_reg;

    // Tracking state.
    logic [DW-1:0]                  distance_reg, distance_next;
    logic [DW-1:0]                  target_reg, target_next;
    logic [fdt_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [fdt_pkg::TIME_W-1:0]     lost_reg, lost_next;

    // Item and intermediate registers.
    logic [fdt_pkg::DEPTH_W-1:0]    depth_reg;
    logic                           bad_reg;
    logic [fdt_pkg::TIME_W-1:0]     dt_reg;
    logic [31:0]                    x_reg;
    logic [IW-1:0]                  idx_reg;
    logic [23:0]                    w_reg;
    logic [QW-1:0]                  a_reg, b_reg, f30_reg, e30_reg;
    logic [fdt_pkg::K_W-1:0]        k_reg;

    // Result register.
    logic [DW-1:0]                  res_dist_reg, res_tgt_reg;
    logic [fdt_pkg::MODE_W-1:0]     res_mode_reg;

    // Tracking logic.
    logic [DW-1:0]                  raw_mag, clamped, dev, start_clamped;
    logic                           sample_ok;
    logic [fdt_pkg::TIME_W:0]       lost_sum;
    logic [fdt_pkg::TIME_W-1:0]     lost_sat;

    // Ease factor logic.
    logic [POS_TOP:0]               pos;
    logic                           far;
    logic [fdt_pkg::INT_IDX_W-1:0]  n_sel;
    logic [QW-1:0]                  ab_diff;
    logic [QW+23:0]                 ab_prod;
    logic [2*QW-1:0]                e_prod;
    logic [31:0]                    e_sum;
    logic [17:0]                    e16, e16_cap;

    // Ease step logic.
    logic [DW-1:0]                  gap, step, cur_new;
    logic [2*DW-1:0]                step_prod;

    assign status.skip = manual_reg || (dt_reg == '0);

    // Sample classification and the new target, mode and lost time.
    always_comb begin
        raw_mag       = depth_reg[DW-1:0];
        sample_ok     = !depth_reg[fdt_pkg::DEPTH_W-1] && (depth_reg != '0) && !bad_reg
                        && (raw_mag <= max_reg);
        clamped       = fdt_pkg::clamp_dist(raw_mag, min_reg, max_reg);
        dev           = (clamped >= target_reg) ? clamped - target_reg : target_reg - clamped;
        lost_sum      = {1'b0, lost_reg} + (fdt_pkg::TIME_W + 1)'(dt_reg);
        lost_sat      = lost_sum[fdt_pkg::TIME_W] ? '1 : lost_sum[fdt_pkg::TIME_W-1:0];
        start_clamped = fdt_pkg::clamp_dist(cfg_wdata, min_reg, max_reg);
        target_next   = target_reg;
        mode_next     = mode_reg;
        lost_next     = lost_reg;
        if (sample_ok) begin
            lost_next = '0;
            if (mode_reg != fdt_pkg::MODE_LOCKED || dev > deadband_reg) begin
                target_next = clamped;
                mode_next   = fdt_pkg::MODE_SEEKING;
            end
        end else begin
            lost_next = lost_sat;
            if (lost_sat >= timeout_reg) begin
                mode_next   = fdt_pkg::MODE_IDLE;
                target_next = max_reg;
            end
        end
    end

    // Table position, interpolation, scaling by the whole-number part and the rounded, capped factor.
    always_comb begin
        pos     = fdt_pkg::POS_W'(x_reg[23:0]) * fdt_pkg::POS_W'(fdt_pkg::EXP_TABLE_ENTRIES);
        far     = (x_reg[31:24] >= 8'(fdt_pkg::INT_LIMIT));
        n_sel   = far ? '0 : x_reg[24 +: fdt_pkg::INT_IDX_W];
        ab_diff = (a_reg >= b_reg) ? a_reg - b_reg : b_reg - a_reg;
        ab_prod = (QW + 24)'(ab_diff) * (QW + 24)'(w_reg);
        e_prod  = (2 * QW)'(f30_reg) * (2 * QW)'(fdt_pkg::INT_EXP[n_sel]);
        e_sum   = 32'(e30_reg) + 32'd8192;
        e16     = e_sum[31:14];
        e16_cap = (e16 > 18'd65536) ? 18'd65536 : e16;
    end

    // Ease step toward the target, then clamp.
    always_comb begin
        gap       = (target_reg >= distance_reg) ? target_reg - distance_reg
                                                 : distance_reg - target_reg;
        step_prod = (2 * DW)'(gap) * (2 * DW)'(k_reg) + (2 * DW)'(32768);
        step      = step_prod[DW+15:16];
        cur_new   = (target_reg >= distance_reg) ? distance_reg + step : distance_reg - step;
        distance_next = fdt_pkg::clamp_dist(cur_new, min_reg, max_reg);
    end

    // Configuration and tracking state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= fdt_pkg::RST_MIN_DISTANCE;
            max_reg      <= fdt_pkg::RST_MAX_DISTANCE;
            rate_reg     <= fdt_pkg::RST_EASE_RATE;
            deadband_reg <= fdt_pkg::RST_DEADBAND;
            timeout_reg  <= fdt_pkg::RST_LOST_TIMEOUT;
            manual_reg   <= 1'b0;
            distance_reg <= fdt_pkg::clamp_dist(fdt_pkg::RST_START_DISTANCE,
                                                fdt_pkg::RST_MIN_DISTANCE,
                                                fdt_pkg::RST_MAX_DISTANCE);
            target_reg   <= fdt_pkg::clamp_dist(fdt_pkg::RST_START_DISTANCE,
                                                fdt_pkg::RST_MIN_DISTANCE,
                                                fdt_pkg::RST_MAX_DISTANCE);
            mode_reg     <= fdt_pkg::MODE_LOCKED;
            lost_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fdt_pkg::CFG_MIN_DISTANCE: min_reg      <= cfg_wdata;
                fdt_pkg::CFG_MAX_DISTANCE: max_reg      <= cfg_wdata;
                fdt_pkg::CFG_EASE_RATE:    rate_reg     <= cfg_wdata[fdt_pkg::RATE_W-1:0];
                fdt_pkg::CFG_DEADBAND:     deadband_reg <= cfg_wdata;
                fdt_pkg::CFG_LOST_TIMEOUT: timeout_reg  <= cfg_wdata[fdt_pkg::TIME_W-1:0];
                fdt_pkg::CFG_START_DISTANCE: begin
                    distance_reg <= start_clamped;
                    target_reg   <= start_clamped;
                    mode_reg     <= fdt_pkg::MODE_LOCKED;
                    lost_reg     <= '0;
                end
                fdt_pkg::CFG_MANUAL_HOLD:  manual_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end else begin
            if (cmd.track) begin
                target_reg <= target_next;
                mode_reg   <= mode_next;
                lost_reg   <= lost_next;
            end
            if (cmd.ease) begin
                distance_reg <= distance_next;
            end
        end
    end

    // Item, intermediate and result registers: payload only, no reset.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            depth_reg <= s_tdata[fdt_pkg::DEPTH_W-1:0];
            dt_reg    <= s_tdata[fdt_pkg::DEPTH_W +: fdt_pkg::TIME_W];
            bad_reg   <= s_tuser;
        end
        if (cmd.track) begin
            x_reg <= 32'(rate_reg) * 32'(dt_reg);
        end
        if (cmd.pos) begin
            idx_reg <= pos[POS_TOP:24];
            w_reg   <= pos[23:0];
        end
        if (cmd.rd_a) begin
            a_reg <= fdt_pkg::FRAC_EXP[idx_reg];
        end
        if (cmd.rd_b) begin
            b_reg <= fdt_pkg::FRAC_EXP[idx_reg + IW'(1)];
        end
        if (cmd.interp) begin
            f30_reg <= (a_reg >= b_reg) ? a_reg - ab_prod[QW+23:24] : a_reg + ab_prod[QW+23:24];
        end
        if (cmd.scale) begin
            e30_reg <= e_prod[2*QW-2:30];
        end
        if (cmd.kcalc) begin
            k_reg <= far ? 17'd65536 : 17'(18'd65536 - e16_cap);
        end
        if (cmd.load_out) begin
            res_dist_reg <= distance_reg;
            res_tgt_reg  <= target_reg;
            res_mode_reg <= manual_reg ? fdt_pkg::MODE_MANUAL : mode_reg;
        end
    end

    assign m_tdata = {4'b0000, res_mode_reg, res_tgt_reg, res_dist_reg};

endmodule

>>> hw/rtl/focus_distance_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus distance tracker core
// Per frame, tracks a depth sample into a target, times out lost readings
// and eases the focus distance toward the target.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Content
// s_*       in         depth sample, frame time; tuser = sample not finite
// m_*       out        focus distance, focus target, focus mode
// cfg_*     in         register write: index and data, no read-back
//
// An item is accepted only while the core is idle. A tracked item runs eight
// datapath steps (tracking with the rate product, table position, two table
// reads, interpolation, scaling, ease factor, ease step) and its result is
// loaded in the result step; only then can a new item be taken. An item with
// zero frame time or under manual hold skips from tracking to the result step.
// A result waiting on m_tready holds only the next item, at its final step;
// that item can already be accepted behind it. Reset is synchronous, active low.
//
module focus_distance_tracker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // depth_sample [17:0], frame_time [33:18], zero fill above
    input  logic [fdt_pkg::S_TDATA_W-1:0]  s_tdata,
    // sample_not_finite [0]
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // focus_distance [16:0], focus_target [33:17], focus_mode [35:34]
    output logic [fdt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [fdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    fdt_pkg::fdt_cmd_t    cmd;
    fdt_pkg::fdt_status_t status;

    // Sequencer.
    fdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state.
    fdt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
